FILE: src/window_sum_statistics_core_assert.svh
// ----------------------------------------------------------------------------
// window_sum_statistics_core assertion macros
// Implication checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WINDOW_SUM_STATISTICS_CORE_ASSERT_SVH
`define WINDOW_SUM_STATISTICS_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define WSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wss assertion failed");

// next-cycle implication
`define WSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wss assertion failed");

`else

`define WSS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WSS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Widths and item types of the window sum statistics core.
// ----------------------------------------------------------------------------
package wss_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 32;
   localparam int SAMPLE_W            = 32;
   localparam int POS_BITS            = 32;
   localparam int SUM_BITS            = 64;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } req_item_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] window_sum;
      logic [SUM_BITS-1:0] weighted_sum;
      logic [SUM_BITS-1:0] variation_sum;
   } rsp_item_type;

endpackage

FILE: src/wss_if.sv
// ----------------------------------------------------------------------------
// wss_if
// Valid/ready channels carrying sample items and result items.
// ----------------------------------------------------------------------------
interface wss_req_if;
   import wss_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface wss_rsp_if;
   import wss_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

FILE: src/window_sum_statistics_core.sv
// ----------------------------------------------------------------------------
// window_sum_statistics_core
// Plain, position-weighted and total-variation sums over sample windows.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        accepted when
//  req_chan  in   sample, last                                   valid && ready
//  rsp_chan  out  window_sum, weighted_sum, variation_sum        valid && ready
//
//  One sample per cycle. Three register stages: input register, product and
//  difference register, accumulators with the result register behind them.
//  The result loads as the window's last sample leaves the product register.
//  Synchronous reset clears the position counter, accumulators and valids.
//  A held result stalls all stages together; otherwise no bubbles.
// ----------------------------------------------------------------------------
module window_sum_statistics_core #(
   parameter int SAMPLE_BITS = wss_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   wss_req_if.sink  req_chan,
   wss_rsp_if.source rsp_chan
);
   import wss_pkg::*;

   `include "window_sum_statistics_core_assert.svh"

   localparam int PROD_BITS = POS_BITS + SAMPLE_BITS;

   logic                   advance;
   logic                   req_accept;
   logic [SAMPLE_BITS-1:0] sample_in;

   // window position tracking
   logic [POS_BITS-1:0]    position_ff, position_in;
   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;

   // stage 1
   logic                   s1_valid_ff;
   logic                   s1_last_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [SAMPLE_BITS-1:0] s1_prev_ff;
   logic [POS_BITS-1:0]    s1_position_ff;
   logic [SAMPLE_BITS-1:0] diff_in;
   logic [PROD_BITS-1:0]   product_in;

   // stage 2
   logic                   s2_valid_ff;
   logic                   s2_last_ff;
   logic [SAMPLE_BITS-1:0] s2_sample_ff;
   logic [SAMPLE_BITS-1:0] s2_diff_ff;
   logic [PROD_BITS-1:0]   s2_product_ff;

   // accumulators
   logic [SUM_BITS-1:0]    sum_acc_ff, sum_acc_in;
   logic [SUM_BITS-1:0]    weighted_acc_ff, weighted_acc_in;
   logic [SUM_BITS-1:0]    variation_acc_ff, variation_acc_in;

   logic                   rsp_valid_ff;
   rsp_item_type           rsp_item_ff;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && advance;
   assign req_chan.ready = advance;
   assign sample_in      = req_chan.item.sample[SAMPLE_BITS-1:0];

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.item  = rsp_item_ff;

   always_comb begin
      if (req_chan.item.last) begin
         position_in = '0;
         prev_in     = '0;
      end else begin
         position_in = position_ff + POS_BITS'(1);
         prev_in     = sample_in;
      end
   end

   always_comb begin
      if (s1_position_ff == '0) begin
         diff_in = '0;
      end else if (s1_sample_ff > s1_prev_ff) begin
         diff_in = s1_sample_ff - s1_prev_ff;
      end else begin
         diff_in = s1_prev_ff - s1_sample_ff;
      end
      product_in = PROD_BITS'(s1_position_ff) * PROD_BITS'(s1_sample_ff);
   end

   always_comb begin
      sum_acc_in       = sum_acc_ff + SUM_BITS'(s2_sample_ff);
      weighted_acc_in  = weighted_acc_ff + SUM_BITS'(s2_product_ff);
      variation_acc_in = variation_acc_ff + SUM_BITS'(s2_diff_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff      <= '0;
         prev_ff          <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         sum_acc_ff       <= '0;
         weighted_acc_ff  <= '0;
         variation_acc_ff <= '0;
      end else begin
         if (req_accept) begin
            position_ff <= position_in;
            prev_ff     <= prev_in;
         end
         if (advance) begin
            s1_valid_ff  <= req_chan.valid;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff && s2_last_ff;
            if (s2_valid_ff) begin
               if (s2_last_ff) begin
                  sum_acc_ff       <= '0;
                  weighted_acc_ff  <= '0;
                  variation_acc_ff <= '0;
               end else begin
                  sum_acc_ff       <= sum_acc_in;
                  weighted_acc_ff  <= weighted_acc_in;
                  variation_acc_ff <= variation_acc_in;
               end
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff     <= req_chan.item.last;
         s1_sample_ff   <= sample_in;
         s1_prev_ff     <= prev_ff;
         s1_position_ff <= position_ff;
         s2_last_ff     <= s1_last_ff;
         s2_sample_ff   <= s1_sample_ff;
         s2_diff_ff     <= diff_in;
         s2_product_ff  <= product_in;
         if (s2_valid_ff && s2_last_ff) begin
            rsp_item_ff.window_sum    <= sum_acc_in;
            rsp_item_ff.weighted_sum  <= weighted_acc_in;
            rsp_item_ff.variation_sum <= variation_acc_in;
         end
      end
   end

   `WSS_ASSERT_NEXT(a_pos_clear, clock, reset, req_accept && req_chan.item.last, position_ff == '0)
   `WSS_ASSERT_NEXT(a_rsp_load, clock, reset, advance && s2_valid_ff && s2_last_ff, rsp_valid_ff)
   `WSS_ASSERT_NEXT(a_acc_clear, clock, reset, advance && s2_valid_ff && s2_last_ff, sum_acc_ff == '0 && weighted_acc_ff == '0 && variation_acc_ff == '0)
   `WSS_ASSERT_NEXT(a_first_diff, clock, reset, advance && s1_valid_ff && s1_position_ff == '0, s2_diff_ff == '0)

endmodule
